// File: sv/cpd_pkg.sv
package cpd_pkg;

  // Fixed-point formats
  localparam int FRAC_BITS = 24;
  localparam int DIV_BITS  = 32;
  localparam int PROD_W    = 40;
  localparam int SUM_W     = 48;
  localparam int PSUM_W    = 43;
  localparam int PROD_N    = 13;

  localparam logic signed [31:0] ONE_Q24 = 32'sd16777216;
  localparam logic signed [31:0] MAX32   = 32'sh7fffffff;
  localparam logic signed [31:0] MIN32   = 32'sh80000000;

  // Register map
  localparam int NUM_REGS = 8;
  localparam int IDX_W    = $clog2(NUM_REGS);
  localparam logic [IDX_W-1:0] REG_FOCAL     = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_PRINCIPAL = IDX_W'(1);
  localparam logic [IDX_W-1:0] REG_K1_K2     = IDX_W'(2);
  localparam logic [IDX_W-1:0] REG_P1_P2     = IDX_W'(3);
  localparam logic [IDX_W-1:0] REG_K3_K4     = IDX_W'(4);
  localparam logic [IDX_W-1:0] REG_K5_K6     = IDX_W'(5);
  localparam logic [IDX_W-1:0] REG_S1_S2     = IDX_W'(6);
  localparam logic [IDX_W-1:0] REG_S3_S4     = IDX_W'(7);

  // Payload carried down the pipeline
  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic signed [31:0] xn;
    logic signed [31:0] yn;
    logic signed [31:0] r2;
    logic signed [31:0] r4;
    logic signed [31:0] r6;
    logic signed [31:0] t1;
    logic signed [31:0] t2;
    logic signed [31:0] t3;
    logic signed [31:0] num;
    logic signed [31:0] den;
    logic signed [31:0] rad;
    logic signed [31:0] xd;
    logic signed [31:0] yd;
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic [PROD_N-1:0][PROD_W-1:0] m;
    logic signed [PSUM_W-1:0] px;
    logic signed [PSUM_W-1:0] py;
    logic bad;
  } pl_t;

  // Q8.24 product, rounded half up
  function automatic logic signed [PROD_W-1:0] mulq(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b);
    p = p + 64'sd8388608;
    return PROD_W'(p >>> FRAC_BITS);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    if (v > SUM_W'(MAX32)) return MAX32;
    if (v < SUM_W'(MIN32)) return MIN32;
    return 32'(v);
  endfunction

  function automatic logic ovf32(input logic signed [SUM_W-1:0] v);
    return (v > SUM_W'(MAX32)) || (v < SUM_W'(MIN32));
  endfunction

  function automatic logic signed [SUM_W-1:0] ext(input logic [PROD_W-1:0] v);
    return SUM_W'($signed(v));
  endfunction

endpackage

// File: sv/cpd_div.sv
// Pipelined rounding divider: q = round(n * 2^24 / d), ties away from zero,
// saturated. One quotient bit per stage; LANES numerators share d.
module cpd_div #(
  parameter int LANES  = 1,
  parameter int SIDE_W = 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic signed [31:0]       n [LANES],
  input  logic signed [31:0]       d,
  input  logic [SIDE_W-1:0]        side_in,
  output logic                     out_valid,
  output logic signed [31:0]       q [LANES],
  output logic                     bad,
  output logic [SIDE_W-1:0]        side_out
);

  localparam int STEPS = cpd_pkg::DIV_BITS;

  logic              vld [0:STEPS];
  logic [31:0]       ad  [0:STEPS];
  logic              dz  [0:STEPS];
  logic [SIDE_W-1:0] sd  [0:STEPS];
  logic              vo;
  logic [SIDE_W-1:0] so;
  logic [31:0]       adm;
  logic [LANES-1:0]  lane_bad;

  assign adm = d[31] ? 32'(-d) : 32'(d);

  // Shared control and divisor chain
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= STEPS; j++) vld[j] <= 1'b0;
      vo <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
      for (int j = 0; j < STEPS; j++) vld[j+1] <= vld[j];
      vo <= vld[STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ad[0] <= adm;
      dz[0] <= (d == '0);
      sd[0] <= side_in;
      for (int j = 0; j < STEPS; j++) begin
        ad[j+1] <= ad[j];
        dz[j+1] <= dz[j];
        sd[j+1] <= sd[j];
      end
      so <= sd[STEPS];
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic [63:0]        rem  [0:STEPS];
    logic [31:0]        qm   [0:STEPS];
    logic               ovf  [0:STEPS];
    logic               neg  [0:STEPS];
    logic               npos [0:STEPS];
    logic               nneg [0:STEPS];
    logic [31:0]        an;
    logic [56:0]        a;
    logic signed [31:0] res;
    logic               res_bad;
    logic signed [31:0] q_r;
    logic               bad_r;

    // Magnitudes plus half the divisor for rounding
    assign an = n[l][31] ? 32'(-n[l]) : 32'(n[l]);
    assign a  = {1'b0, an, 24'b0} + 57'(adm >> 1);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[0]  <= 64'(a);
        qm[0]   <= '0;
        ovf[0]  <= ({7'b0, a} >= {adm, 32'b0});
        neg[0]  <= n[l][31] ^ d[31];
        npos[0] <= !n[l][31] && (n[l] != '0);
        nneg[0] <= n[l][31];
      end
    end

    // Restoring steps, most significant quotient bit first
    for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic [63:0] sub;
      assign sub = {32'b0, ad[j]} << (STEPS - 1 - j);
      always_ff @(posedge clk) begin
        if (en) begin
          if (rem[j] >= sub) begin
            rem[j+1] <= rem[j] - sub;
            qm[j+1]  <= qm[j] | (32'd1 << (STEPS - 1 - j));
          end else begin
            rem[j+1] <= rem[j];
            qm[j+1]  <= qm[j];
          end
          ovf[j+1]  <= ovf[j];
          neg[j+1]  <= neg[j];
          npos[j+1] <= npos[j];
          nneg[j+1] <= nneg[j];
        end
      end
    end

    // Sign and saturation
    always_comb begin
      res     = $signed(qm[STEPS]);
      res_bad = 1'b0;
      if (dz[STEPS]) begin
        res_bad = 1'b1;
        if (npos[STEPS])      res = cpd_pkg::MAX32;
        else if (nneg[STEPS]) res = cpd_pkg::MIN32;
        else                  res = '0;
      end else if (ovf[STEPS]) begin
        res_bad = 1'b1;
        res     = neg[STEPS] ? cpd_pkg::MIN32 : cpd_pkg::MAX32;
      end else if (!neg[STEPS]) begin
        if (qm[STEPS][31]) begin
          res_bad = 1'b1;
          res     = cpd_pkg::MAX32;
        end
      end else begin
        if (qm[STEPS] > 32'h80000000) begin
          res_bad = 1'b1;
          res     = cpd_pkg::MIN32;
        end else begin
          res = $signed(32'(-qm[STEPS]));
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_r   <= res;
        bad_r <= res_bad;
      end
    end

    assign q[l]        = q_r;
    assign lane_bad[l] = bad_r;
  end

  assign out_valid = vo;
  assign bad       = |lane_bad;
  assign side_out  = so;

endmodule

// File: sv/camera_projection_with_distortion_top.sv
// Pipeline: two dividers with one quotient bit per stage, plus 12 multiply
// and sum stages.
// Throughput: one point per cycle; a stalled output freezes the whole pipeline.
// Reset (rst, synchronous): clears all valid bits and the eight coefficient
// registers to zero.
module camera_projection_with_distortion_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [cpd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [63:0]                 cfg_data,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [95:0]                 s_tdata,   // cam_x, cam_y, cam_z
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [95:0]                 m_tdata,   // screen_x, screen_y, depth
  output logic                        m_tuser    // invalid
);

  logic [63:0] cfg_regs [cpd_pkg::NUM_REGS];

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < cpd_pkg::NUM_REGS; i++) cfg_regs[i] <= '0;
    end else if (cfg_we) begin
      cfg_regs[cfg_index] <= cfg_data;
    end
  end

  logic signed [31:0] fx, fy, cx, cy, k1, k2, k3, k4, k5, k6, p1, p2, s1, s2, s3, s4;
  assign fx = $signed(cfg_regs[cpd_pkg::REG_FOCAL][63:32]);
  assign fy = $signed(cfg_regs[cpd_pkg::REG_FOCAL][31:0]);
  assign cx = $signed(cfg_regs[cpd_pkg::REG_PRINCIPAL][63:32]);
  assign cy = $signed(cfg_regs[cpd_pkg::REG_PRINCIPAL][31:0]);
  assign k1 = $signed(cfg_regs[cpd_pkg::REG_K1_K2][63:32]);
  assign k2 = $signed(cfg_regs[cpd_pkg::REG_K1_K2][31:0]);
  assign p1 = $signed(cfg_regs[cpd_pkg::REG_P1_P2][63:32]);
  assign p2 = $signed(cfg_regs[cpd_pkg::REG_P1_P2][31:0]);
  assign k3 = $signed(cfg_regs[cpd_pkg::REG_K3_K4][63:32]);
  assign k4 = $signed(cfg_regs[cpd_pkg::REG_K3_K4][31:0]);
  assign k5 = $signed(cfg_regs[cpd_pkg::REG_K5_K6][63:32]);
  assign k6 = $signed(cfg_regs[cpd_pkg::REG_K5_K6][31:0]);
  assign s1 = $signed(cfg_regs[cpd_pkg::REG_S1_S2][63:32]);
  assign s2 = $signed(cfg_regs[cpd_pkg::REG_S1_S2][31:0]);
  assign s3 = $signed(cfg_regs[cpd_pkg::REG_S3_S4][63:32]);
  assign s4 = $signed(cfg_regs[cpd_pkg::REG_S3_S4][31:0]);

  localparam int PL_W = $bits(cpd_pkg::pl_t);

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // Normalise x and y by depth
  cpd_pkg::pl_t      in_pl;
  logic signed [31:0] d1_n [2];
  logic signed [31:0] d1_q [2];
  logic               d1_v, d1_bad;
  logic [PL_W-1:0]    d1_side;

  always_comb begin
    in_pl   = '0;
    in_pl.x = $signed(s_tdata[31:0]);
    in_pl.y = $signed(s_tdata[63:32]);
    in_pl.z = $signed(s_tdata[95:64]);
  end
  assign d1_n[0] = in_pl.x;
  assign d1_n[1] = in_pl.y;

  cpd_div #(.LANES(2), .SIDE_W(PL_W)) u_div_xy (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_tvalid),
    .n(d1_n), .d(in_pl.z), .side_in(PL_W'(in_pl)),
    .out_valid(d1_v), .q(d1_q), .bad(d1_bad), .side_out(d1_side)
  );

  cpd_pkg::pl_t a0;
  always_comb begin
    a0     = cpd_pkg::pl_t'(d1_side);
    a0.xn  = d1_q[0];
    a0.yn  = d1_q[1];
    a0.bad = d1_bad;
  end

  cpd_pkg::pl_t a1, a2, a3, a4, a5, a6, a7, a8;
  cpd_pkg::pl_t a1_next, a2_next, a3_next, a4_next, a5_next, a6_next, a7_next, a8_next;
  logic v_a1, v_a2, v_a3, v_a4, v_a5, v_a6, v_a7, v_a8;

  logic signed [cpd_pkg::SUM_W-1:0] r2_sum, t1_sum, t2_sum, t3_sum;
  logic signed [cpd_pkg::SUM_W-1:0] num_sum, den_sum;
  logic signed [31:0]               r2_sat;

  // Radius powers, coefficient products and the radial fraction terms
  always_comb begin
    a1_next      = a0;
    a1_next.m[0] = cpd_pkg::mulq(a0.xn, a0.xn);
    a1_next.m[1] = cpd_pkg::mulq(a0.yn, a0.yn);
    a1_next.m[2] = cpd_pkg::mulq(a0.xn, a0.yn);

    a2_next  = a1;
    r2_sum   = cpd_pkg::ext(a1.m[0]) + cpd_pkg::ext(a1.m[1]);
    r2_sat   = cpd_pkg::sat32(r2_sum);
    t1_sum   = cpd_pkg::ext(a1.m[2]) <<< 1;
    t2_sum   = cpd_pkg::SUM_W'(r2_sat) + (cpd_pkg::ext(a1.m[0]) <<< 1);
    t3_sum   = cpd_pkg::SUM_W'(r2_sat) + (cpd_pkg::ext(a1.m[1]) <<< 1);
    a2_next.r2  = r2_sat;
    a2_next.t1  = cpd_pkg::sat32(t1_sum);
    a2_next.t2  = cpd_pkg::sat32(t2_sum);
    a2_next.t3  = cpd_pkg::sat32(t3_sum);
    a2_next.bad = a1.bad | cpd_pkg::ovf32(r2_sum) | cpd_pkg::ovf32(t1_sum)
                | cpd_pkg::ovf32(t2_sum) | cpd_pkg::ovf32(t3_sum);

    a3_next      = a2;
    a3_next.m[0] = cpd_pkg::mulq(a2.r2, a2.r2);

    a4_next     = a3;
    a4_next.r4  = cpd_pkg::sat32(cpd_pkg::ext(a3.m[0]));
    a4_next.bad = a3.bad | cpd_pkg::ovf32(cpd_pkg::ext(a3.m[0]));

    a5_next       = a4;
    a5_next.m[0]  = cpd_pkg::mulq(a4.r4, a4.r2);
    a5_next.m[1]  = cpd_pkg::mulq(k1, a4.r2);
    a5_next.m[2]  = cpd_pkg::mulq(k2, a4.r4);
    a5_next.m[3]  = cpd_pkg::mulq(k4, a4.r2);
    a5_next.m[4]  = cpd_pkg::mulq(k5, a4.r4);
    a5_next.m[5]  = cpd_pkg::mulq(p1, a4.t1);
    a5_next.m[6]  = cpd_pkg::mulq(p2, a4.t2);
    a5_next.m[7]  = cpd_pkg::mulq(s1, a4.r2);
    a5_next.m[8]  = cpd_pkg::mulq(s2, a4.r4);
    a5_next.m[9]  = cpd_pkg::mulq(p1, a4.t3);
    a5_next.m[10] = cpd_pkg::mulq(p2, a4.t1);
    a5_next.m[11] = cpd_pkg::mulq(s3, a4.r2);
    a5_next.m[12] = cpd_pkg::mulq(s4, a4.r4);

    a6_next     = a5;
    a6_next.r6  = cpd_pkg::sat32(cpd_pkg::ext(a5.m[0]));
    a6_next.bad = a5.bad | cpd_pkg::ovf32(cpd_pkg::ext(a5.m[0]));
    a6_next.px  = cpd_pkg::PSUM_W'(cpd_pkg::ext(a5.m[5]) + cpd_pkg::ext(a5.m[6])
                + cpd_pkg::ext(a5.m[7]) + cpd_pkg::ext(a5.m[8]));
    a6_next.py  = cpd_pkg::PSUM_W'(cpd_pkg::ext(a5.m[9]) + cpd_pkg::ext(a5.m[10])
                + cpd_pkg::ext(a5.m[11]) + cpd_pkg::ext(a5.m[12]));

    a7_next      = a6;
    a7_next.m[0] = cpd_pkg::mulq(k3, a6.r6);
    a7_next.m[5] = cpd_pkg::mulq(k6, a6.r6);

    a8_next     = a7;
    num_sum     = cpd_pkg::SUM_W'(cpd_pkg::ONE_Q24) + cpd_pkg::ext(a7.m[1])
                + cpd_pkg::ext(a7.m[2]) + cpd_pkg::ext(a7.m[0]);
    den_sum     = cpd_pkg::SUM_W'(cpd_pkg::ONE_Q24) + cpd_pkg::ext(a7.m[3])
                + cpd_pkg::ext(a7.m[4]) + cpd_pkg::ext(a7.m[5]);
    a8_next.num = cpd_pkg::sat32(num_sum);
    a8_next.den = cpd_pkg::sat32(den_sum);
    a8_next.bad = a7.bad | cpd_pkg::ovf32(num_sum) | cpd_pkg::ovf32(den_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a1 <= 1'b0; v_a2 <= 1'b0; v_a3 <= 1'b0; v_a4 <= 1'b0;
      v_a5 <= 1'b0; v_a6 <= 1'b0; v_a7 <= 1'b0; v_a8 <= 1'b0;
    end else if (en) begin
      v_a1 <= d1_v; v_a2 <= v_a1; v_a3 <= v_a2; v_a4 <= v_a3;
      v_a5 <= v_a4; v_a6 <= v_a5; v_a7 <= v_a6; v_a8 <= v_a7;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a1_next; a2 <= a2_next; a3 <= a3_next; a4 <= a4_next;
      a5 <= a5_next; a6 <= a6_next; a7 <= a7_next; a8 <= a8_next;
    end
  end

  // Radial factor num / den
  logic signed [31:0] d2_n [1];
  logic signed [31:0] d2_q [1];
  logic               d2_v, d2_bad;
  logic [PL_W-1:0]    d2_side;

  assign d2_n[0] = a8.num;

  cpd_div #(.LANES(1), .SIDE_W(PL_W)) u_div_rad (
    .clk(clk), .rst(rst), .en(en), .in_valid(v_a8),
    .n(d2_n), .d(a8.den), .side_in(PL_W'(a8)),
    .out_valid(d2_v), .q(d2_q), .bad(d2_bad), .side_out(d2_side)
  );

  cpd_pkg::pl_t b0, b1, b2, b3, b4;
  cpd_pkg::pl_t b1_next, b2_next, b3_next, b4_next;
  logic v_b1, v_b2, v_b3, v_b4;
  logic signed [cpd_pkg::SUM_W-1:0] xd_sum, yd_sum, sx_sum, sy_sum;

  // Distorted point, then intrinsics
  always_comb begin
    b0     = cpd_pkg::pl_t'(d2_side);
    b0.rad = d2_q[0];
    b0.bad = b0.bad | d2_bad;

    b1_next      = b0;
    b1_next.m[0] = cpd_pkg::mulq(b0.xn, b0.rad);
    b1_next.m[1] = cpd_pkg::mulq(b0.yn, b0.rad);

    b2_next     = b1;
    xd_sum      = cpd_pkg::ext(b1.m[0]) + cpd_pkg::SUM_W'(b1.px);
    yd_sum      = cpd_pkg::ext(b1.m[1]) + cpd_pkg::SUM_W'(b1.py);
    b2_next.xd  = cpd_pkg::sat32(xd_sum);
    b2_next.yd  = cpd_pkg::sat32(yd_sum);
    b2_next.bad = b1.bad | cpd_pkg::ovf32(xd_sum) | cpd_pkg::ovf32(yd_sum);

    b3_next      = b2;
    b3_next.m[0] = cpd_pkg::mulq(b2.xd, fx);
    b3_next.m[1] = cpd_pkg::mulq(b2.yd, fy);

    b4_next     = b3;
    sx_sum      = cpd_pkg::ext(b3.m[0]) + cpd_pkg::SUM_W'(cx);
    sy_sum      = cpd_pkg::ext(b3.m[1]) + cpd_pkg::SUM_W'(cy);
    b4_next.sx  = cpd_pkg::sat32(sx_sum);
    b4_next.sy  = cpd_pkg::sat32(sy_sum);
    b4_next.bad = b3.bad | cpd_pkg::ovf32(sx_sum) | cpd_pkg::ovf32(sy_sum);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_b1 <= 1'b0; v_b2 <= 1'b0; v_b3 <= 1'b0; v_b4 <= 1'b0;
    end else if (en) begin
      v_b1 <= d2_v; v_b2 <= v_b1; v_b3 <= v_b2; v_b4 <= v_b3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1 <= b1_next; b2 <= b2_next; b3 <= b3_next; b4 <= b4_next;
    end
  end

  // Output beat
  assign m_tvalid = v_b4;
  assign m_tdata  = {b4.z, b4.sy, b4.sx};
  assign m_tuser  = b4.bad;

endmodule
